FILE: hw/rtl/hkm_pkg.sv
//------------------------------------------------------------------------------
// hkm_pkg: shared types and constants of the k-way heap merge.
// Holds the key type, result kinds, phase, state and command codes, the status struct and the key compare.
//------------------------------------------------------------------------------
`default_nettype none
package hkm_pkg;

   localparam int MAX_STREAMS_DEF = 64;
   localparam int KEY_WORDS = 4;
   localparam int WORD_W = 64;
   localparam int KEY_W = KEY_WORDS * WORD_W;
   localparam int STREAM_W = 6;
   localparam int CNT_W = 7;
   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [1:0] {
      PHASE_LOAD,
      PHASE_MERGE,
      PHASE_DONE
   } phase_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_WAIT,
      ST_UP_CMP,
      ST_LAST_RD,
      ST_LAST_WAIT,
      ST_DN_RD,
      ST_DN_WAIT,
      ST_DN_CMP,
      ST_TOP_RD,
      ST_TOP_WAIT,
      ST_OUT
   } state_type;

   // Datapath commands.
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_UP_RD,
      CMD_UP_STEP,
      CMD_LAST_RD,
      CMD_LAST_SET,
      CMD_DN_RD,
      CMD_DN_STEP,
      CMD_TOP_RD,
      CMD_EMIT_TOP,
      CMD_EMIT_ERR,
      CMD_EMIT_DONE,
      CMD_SEND
   } cmd_type;

   // Status to the controller. The in_* fields and load_next describe the
   // item on offer; load_last describes the load position already reached.
   typedef struct packed {
      logic in_valid;
      logic in_ok;
      logic in_exh;
      logic load_last;
      logic load_next;
      phase_type phase;
      logic heap_empty;
      logic up_top;
      logic up_stop;
      logic dn_leaf;
      logic dn_stop;
      logic rsp_busy;
   } status_type;

   // Signed lexicographic compare: a not greater than b.
   function automatic logic key_le(key_type a, key_type b);
      logic [KEY_W-1:0] x;
      logic [KEY_W-1:0] y;
      x = a;
      y = b;
      for (int i = 0; i < KEY_WORDS; i++) begin
         x[KEY_W-1-i*WORD_W] = ~x[KEY_W-1-i*WORD_W];
         y[KEY_W-1-i*WORD_W] = ~y[KEY_W-1-i*WORD_W];
      end
      return x <= y;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hkm_if.sv
//------------------------------------------------------------------------------
// hkm_req_if / hkm_rsp_if: valid-ready channels of the heap merge.
// One transfer happens at a rising edge with valid and ready high.
//------------------------------------------------------------------------------
`default_nettype none
interface hkm_req_if;
   logic valid;
   logic ready;
   logic [5:0] stream;
   logic exhausted;
   logic signed [63:0] key_word0;
   logic signed [63:0] key_word1;
   logic signed [63:0] key_word2;
   logic signed [63:0] key_word3;
   modport source (output valid, stream, exhausted, key_word0, key_word1, key_word2,
                   key_word3, input ready);
   modport sink (input valid, stream, exhausted, key_word0, key_word1, key_word2,
                 key_word3, output ready);
endinterface

interface hkm_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [5:0] source_stream;
   logic signed [63:0] out_word0;
   logic signed [63:0] out_word1;
   logic signed [63:0] out_word2;
   logic signed [63:0] out_word3;
   modport source (output valid, kind, source_stream, out_word0, out_word1, out_word2,
                   out_word3, input ready);
   modport sink (input valid, kind, source_stream, out_word0, out_word1, out_word2,
                 out_word3, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/heap_kway_merge.sv
//------------------------------------------------------------------------------
// heap_kway_merge: k-way merge of sorted streams through a binary min-heap.
// Top level joining the sequencer and the datapath.
//------------------------------------------------------------------------------
// One item is handled at a time; each heap level steps through an index read,
// a key read, and a compare and move. A load record climbs the heap level by
// level until it stops or reaches the top; a load exhausted mark only advances
// the load position, and the last load item then reads the top and posts the
// result. A merge record sinks level by level from the top, and an exhausted
// mark first fetches the last heap entry. The result then sits in an output
// register, so the next item is taken right away; only a result that is still
// waiting when the next one is ready stalls it.
`default_nettype none
module heap_kway_merge #(
   parameter int MAX_STREAMS = hkm_pkg::MAX_STREAMS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata,
   hkm_req_if.sink         req,
   hkm_rsp_if.source       rsp
);

   hkm_pkg::cmd_type cmd;
   hkm_pkg::status_type sts;

   // Sequencer.
   hkm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .sts(sts), .cmd(cmd)
   );

   // Datapath.
   hkm_dp #(.MAX_STREAMS(MAX_STREAMS)) u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .cmd(cmd), .sts(sts), .req(req), .rsp(rsp)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/hkm_ctrl.sv
//------------------------------------------------------------------------------
// hkm_ctrl: sequencer of the heap merge.
// Steps sift-up and sift-down one heap level at a time through the datapath.
//------------------------------------------------------------------------------
`default_nettype none
module hkm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hkm_pkg::status_type sts,
   output hkm_pkg::cmd_type       cmd
);

   hkm_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command.
   always_comb begin
      state_in = state_ff;
      cmd = hkm_pkg::CMD_NONE;
      case (state_ff)
         hkm_pkg::ST_IDLE: begin
            if (sts.in_valid) begin
               cmd = hkm_pkg::CMD_ACCEPT;
               if (sts.phase == hkm_pkg::PHASE_DONE) begin
                  state_in = hkm_pkg::ST_OUT;
               end else if (!sts.in_ok) begin
                  state_in = hkm_pkg::ST_OUT;
               end else if (sts.phase == hkm_pkg::PHASE_LOAD) begin
                  if (!sts.in_exh) state_in = hkm_pkg::ST_UP_RD;
                  else if (sts.load_next) state_in = hkm_pkg::ST_TOP_RD;
               end else if (sts.in_exh) begin
                  state_in = hkm_pkg::ST_LAST_RD;
               end else begin
                  state_in = hkm_pkg::ST_DN_RD;
               end
            end
         end
         hkm_pkg::ST_UP_RD: begin
            if (sts.up_top) begin
               cmd = hkm_pkg::CMD_UP_STEP;
               state_in = sts.load_last ? hkm_pkg::ST_TOP_RD : hkm_pkg::ST_IDLE;
            end else begin
               cmd = hkm_pkg::CMD_UP_RD;
               state_in = hkm_pkg::ST_UP_WAIT;
            end
         end
         hkm_pkg::ST_UP_WAIT: state_in = hkm_pkg::ST_UP_CMP;
         hkm_pkg::ST_UP_CMP: begin
            cmd = hkm_pkg::CMD_UP_STEP;
            if (sts.up_stop) begin
               state_in = sts.load_last ? hkm_pkg::ST_TOP_RD : hkm_pkg::ST_IDLE;
            end else begin
               state_in = hkm_pkg::ST_UP_RD;
            end
         end
         hkm_pkg::ST_LAST_RD: begin
            cmd = hkm_pkg::CMD_LAST_RD;
            state_in = hkm_pkg::ST_LAST_WAIT;
         end
         hkm_pkg::ST_LAST_WAIT: begin
            cmd = hkm_pkg::CMD_LAST_SET;
            state_in = hkm_pkg::ST_DN_RD;
         end
         hkm_pkg::ST_DN_RD: begin
            cmd = hkm_pkg::CMD_DN_RD;
            state_in = hkm_pkg::ST_DN_WAIT;
         end
         hkm_pkg::ST_DN_WAIT: state_in = hkm_pkg::ST_DN_CMP;
         hkm_pkg::ST_DN_CMP: begin
            cmd = hkm_pkg::CMD_DN_STEP;
            state_in = (sts.dn_leaf || sts.dn_stop) ? hkm_pkg::ST_TOP_RD : hkm_pkg::ST_DN_RD;
         end
         hkm_pkg::ST_TOP_RD: begin
            cmd = hkm_pkg::CMD_TOP_RD;
            state_in = hkm_pkg::ST_TOP_WAIT;
         end
         hkm_pkg::ST_TOP_WAIT: begin
            cmd = hkm_pkg::CMD_EMIT_TOP;
            state_in = hkm_pkg::ST_OUT;
         end
         hkm_pkg::ST_OUT: begin
            // Hand the result on once the output register is free.
            if (!sts.rsp_busy) begin
               cmd = hkm_pkg::CMD_SEND;
               state_in = hkm_pkg::ST_IDLE;
            end
         end
         default: state_in = hkm_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/hkm_dp.sv
//------------------------------------------------------------------------------
// hkm_dp: datapath of the heap merge.
// Holds the key store, the heap of stream numbers, counters and the result.
//------------------------------------------------------------------------------
`default_nettype none
module hkm_dp #(
   parameter int MAX_STREAMS = hkm_pkg::MAX_STREAMS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [6:0]        csr_wdata,
   input  wire hkm_pkg::cmd_type  cmd,
   output hkm_pkg::status_type    sts,
   hkm_req_if.sink                req,
   hkm_rsp_if.source              rsp
);

   localparam int IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
   localparam int NW = $clog2(MAX_STREAMS + 1);
   localparam int SW = hkm_pkg::STREAM_W;
   localparam int XW = (IW > SW) ? IW : SW;

   // Key store and heap order store, each read at up to two addresses a cycle.
   hkm_pkg::key_type keys_mem [MAX_STREAMS];
   logic [XW-1:0] heap_mem [MAX_STREAMS];

   logic [6:0] count_ff;
   hkm_pkg::phase_type phase_ff;
   logic [NW-1:0] load_ff;
   logic [NW-1:0] heap_n_ff;
   logic [SW-1:0] await_ff;
   logic [XW-1:0] piv_ff;
   hkm_pkg::key_type pkey_ff;
   logic [NW-1:0] idx_ff;

   // Read results.
   logic [XW-1:0] ha_ff, hb_ff;
   hkm_pkg::key_type ka_ff, kb_ff;
   logic two_ff;
   logic rd_ph_ff;

   // Result being built, then the output register.
   logic rv_ff;
   logic [1:0] kind_ff;
   logic [SW-1:0] src_ff;
   hkm_pkg::key_type okey_ff;
   logic [1:0] rkind_ff;
   logic [SW-1:0] rsrc_ff;
   hkm_pkg::key_type rkey_ff;

   logic [NW-1:0] eff_cnt;
   logic [NW:0] child;
   logic s_ok;
   logic [NW-1:0] parent;

   always_comb begin
      if (count_ff == 7'd0) eff_cnt = NW'(1);
      else if (32'(count_ff) > MAX_STREAMS) eff_cnt = NW'(MAX_STREAMS);
      else eff_cnt = NW'(count_ff);
      parent = (idx_ff - NW'(1)) >> 1;
      child = {idx_ff, 1'b1};
      s_ok = (phase_ff == hkm_pkg::PHASE_LOAD) ?
             ((NW+1)'(req.stream) == {1'b0, load_ff}) && (32'(req.stream) < MAX_STREAMS) :
             (req.stream == await_ff) && (32'(req.stream) < MAX_STREAMS);
   end

   assign req.ready = (cmd == hkm_pkg::CMD_ACCEPT);

   // Status to the controller.
   always_comb begin
      sts.in_valid = req.valid;
      sts.in_ok = s_ok;
      sts.in_exh = req.exhausted;
      sts.load_last = (load_ff >= eff_cnt);
      sts.load_next = ((load_ff + NW'(1)) >= eff_cnt);
      sts.phase = phase_ff;
      sts.heap_empty = (heap_n_ff == '0);
      sts.up_top = (idx_ff == '0);
      sts.up_stop = hkm_pkg::key_le(ka_ff, pkey_ff);
      sts.dn_leaf = (child >= (NW+1)'(heap_n_ff));
      sts.dn_stop = hkm_pkg::key_le(pkey_ff, (two_ff && hkm_pkg::key_le(kb_ff, ka_ff)) ?
                                     kb_ff : ka_ff);
      sts.rsp_busy = rv_ff && !rsp.ready;
   end

   // Two-phase reads: index store, then key store.
   logic [NW:0] rd_a_idx;
   always_ff @(posedge clock) begin
      rd_ph_ff <= 1'b0;
      if (cmd == hkm_pkg::CMD_UP_RD) begin
         ha_ff <= heap_mem[parent[IW-1:0]];
         rd_ph_ff <= 1'b1;
      end
      if (cmd == hkm_pkg::CMD_DN_RD) begin
         ha_ff <= heap_mem[child[IW-1:0]];
         if (child + (NW+1)'(1) < (NW+1)'(heap_n_ff))
            hb_ff <= heap_mem[IW'(child + (NW+1)'(1))];
         two_ff <= (child + (NW+1)'(1) < (NW+1)'(heap_n_ff));
         rd_ph_ff <= 1'b1;
      end
      if (cmd == hkm_pkg::CMD_LAST_RD) ha_ff <= heap_mem[IW'(heap_n_ff)];
      if (cmd == hkm_pkg::CMD_TOP_RD) ha_ff <= heap_mem[0];
      if (rd_ph_ff) begin
         ka_ff <= keys_mem[ha_ff[IW-1:0]];
         kb_ff <= keys_mem[hb_ff[IW-1:0]];
      end
      if (cmd == hkm_pkg::CMD_LAST_SET) begin
         piv_ff <= ha_ff;
         pkey_ff <= keys_mem[ha_ff[IW-1:0]];
      end
      if (cmd == hkm_pkg::CMD_EMIT_TOP) okey_ff <= keys_mem[ha_ff[IW-1:0]];
      if (cmd == hkm_pkg::CMD_ACCEPT) begin
         piv_ff <= XW'(req.stream);
         pkey_ff <= {req.key_word0, req.key_word1, req.key_word2, req.key_word3};
         if (phase_ff != hkm_pkg::PHASE_DONE && s_ok && !req.exhausted)
            keys_mem[req.stream[IW-1:0]] <=
               {req.key_word0, req.key_word1, req.key_word2, req.key_word3};
      end
      // Heap moves.
      if (cmd == hkm_pkg::CMD_UP_STEP) begin
         if (idx_ff == '0 || hkm_pkg::key_le(ka_ff, pkey_ff)) heap_mem[idx_ff[IW-1:0]] <= piv_ff;
         else heap_mem[idx_ff[IW-1:0]] <= ha_ff;
      end
      if (cmd == hkm_pkg::CMD_DN_STEP) begin
         if (sts.dn_leaf || sts.dn_stop) heap_mem[idx_ff[IW-1:0]] <= piv_ff;
         else heap_mem[idx_ff[IW-1:0]] <= (two_ff && hkm_pkg::key_le(kb_ff, ka_ff)) ?
                                          hb_ff : ha_ff;
      end
   end
   assign rd_a_idx = child;

   // Control state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd2;
         phase_ff <= hkm_pkg::PHASE_LOAD;
         load_ff <= '0;
         heap_n_ff <= '0;
         await_ff <= '0;
         idx_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (csr_we) count_ff <= csr_wdata;
         if (cmd == hkm_pkg::CMD_SEND) rv_ff <= 1'b1;
         else if (rsp.ready) rv_ff <= 1'b0;
         case (cmd)
            hkm_pkg::CMD_ACCEPT: begin
               if (phase_ff == hkm_pkg::PHASE_DONE) begin
                  kind_ff <= hkm_pkg::KIND_DONE;
                  src_ff <= '0;
               end else if (!s_ok) begin
                  kind_ff <= hkm_pkg::KIND_ERROR;
                  src_ff <= (phase_ff == hkm_pkg::PHASE_LOAD) ? SW'(load_ff) : await_ff;
               end else if (phase_ff == hkm_pkg::PHASE_LOAD) begin
                  load_ff <= load_ff + NW'(1);
                  idx_ff <= heap_n_ff;
               end else begin
                  idx_ff <= '0;
                  if (req.exhausted) heap_n_ff <= heap_n_ff - NW'(1);
               end
            end
            hkm_pkg::CMD_UP_STEP: begin
               if (idx_ff == '0 || hkm_pkg::key_le(ka_ff, pkey_ff)) begin
                  heap_n_ff <= heap_n_ff + NW'(1);
               end else begin
                  idx_ff <= parent;
               end
            end
            hkm_pkg::CMD_DN_STEP: begin
               if (!(sts.dn_leaf || sts.dn_stop))
                  idx_ff <= (two_ff && hkm_pkg::key_le(kb_ff, ka_ff)) ?
                            NW'(rd_a_idx + (NW+1)'(1)) : NW'(rd_a_idx);
            end
            hkm_pkg::CMD_EMIT_TOP: begin
               if (heap_n_ff == '0) begin
                  phase_ff <= hkm_pkg::PHASE_DONE;
                  kind_ff <= hkm_pkg::KIND_DONE;
                  src_ff <= '0;
               end else begin
                  phase_ff <= hkm_pkg::PHASE_MERGE;
                  kind_ff <= hkm_pkg::KIND_RECORD;
                  src_ff <= SW'(ha_ff);
                  await_ff <= SW'(ha_ff);
               end
            end
            // Move the finished result into the output register.
            hkm_pkg::CMD_SEND: begin
               rkind_ff <= kind_ff;
               rsrc_ff <= src_ff;
               rkey_ff <= (kind_ff == hkm_pkg::KIND_RECORD) ? okey_ff : '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.kind = rkind_ff;
   assign rsp.source_stream = rsrc_ff;
   assign rsp.out_word0 = rkey_ff[255:192];
   assign rsp.out_word1 = rkey_ff[191:128];
   assign rsp.out_word2 = rkey_ff[127:64];
   assign rsp.out_word3 = rkey_ff[63:0];

endmodule
`default_nettype wire
